// File: hdl/mtb_pkg.sv
package mtb_pkg;

   localparam int unsigned CHAN_WIDTH  = 8;
   localparam int unsigned SUM_WIDTH   = 30;
   localparam int unsigned COUNT_WIDTH = 23;
   localparam int unsigned RGB_WIDTH   = 10;
   localparam int unsigned QUO_WIDTH   = 8;
   localparam int unsigned STEP_WIDTH  = 3;

   localparam longint unsigned MAX_PIXELS = 64'd4194304;
   localparam longint unsigned COUNT_MAX  = (64'd1 << COUNT_WIDTH) - 64'd1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT =
      (MAX_PIXELS > COUNT_MAX) ? COUNT_WIDTH'(COUNT_MAX) : COUNT_WIDTH'(MAX_PIXELS);

   // floor(s/3) = (s*683)>>11 for every s up to 765
   localparam int unsigned GRAY_RECIP = 683;
   localparam int unsigned GRAY_SHIFT = 11;
   localparam int unsigned PROD_WIDTH = 20;

   localparam logic [CHAN_WIDTH-1:0] LEVEL_WHITE = 8'd255;
   localparam logic [CHAN_WIDTH-1:0] LEVEL_BLACK = 8'd0;

   localparam logic KIND_ACCUM  = 1'b0;
   localparam logic KIND_THRESH = 1'b1;

   typedef struct packed {
      logic                   start;
      logic [SUM_WIDTH-1:0]   dividend;
      logic [COUNT_WIDTH-1:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [QUO_WIDTH-1:0] quotient;
   } div_stat_type;

endpackage

// File: hdl/mtb_ifs.sv
interface mtb_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [mtb_pkg::CHAN_WIDTH-1:0] red;
   logic [mtb_pkg::CHAN_WIDTH-1:0] green;
   logic [mtb_pkg::CHAN_WIDTH-1:0] blue;
   logic                           last_pixel;

   modport source (output valid, req_type, red, green, blue, last_pixel, input ready);
   modport sink (input valid, req_type, red, green, blue, last_pixel, output ready);
endinterface

interface mtb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mtb_pkg::CHAN_WIDTH-1:0] level;
   logic [mtb_pkg::CHAN_WIDTH-1:0] threshold;
   logic                           end_of_frame;

   modport source (output valid, level, threshold, end_of_frame, input ready);
   modport sink (input valid, level, threshold, end_of_frame, output ready);
endinterface

// File: hdl/mtb_gray.sv
module mtb_gray (
   input  logic                           clock,
   input  logic                           load,
   input  logic [mtb_pkg::CHAN_WIDTH-1:0] red,
   input  logic [mtb_pkg::CHAN_WIDTH-1:0] green,
   input  logic [mtb_pkg::CHAN_WIDTH-1:0] blue,
   output logic [mtb_pkg::CHAN_WIDTH-1:0] gray
);

   logic [mtb_pkg::RGB_WIDTH-1:0]  rgb_sum;
   logic [mtb_pkg::PROD_WIDTH-1:0] prod;
   logic [mtb_pkg::CHAN_WIDTH-1:0] gray_in;
   logic [mtb_pkg::CHAN_WIDTH-1:0] gray_ff;

   assign rgb_sum = mtb_pkg::RGB_WIDTH'(red) + mtb_pkg::RGB_WIDTH'(green)
                  + mtb_pkg::RGB_WIDTH'(blue);
   // divide by three through the reciprocal
   assign prod    = mtb_pkg::PROD_WIDTH'(rgb_sum)
                  * mtb_pkg::PROD_WIDTH'(mtb_pkg::GRAY_RECIP);
   assign gray_in = prod[mtb_pkg::GRAY_SHIFT +: mtb_pkg::CHAN_WIDTH];
   assign gray    = gray_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         gray_ff <= gray_in;
      end
   end

endmodule

// File: hdl/mtb_divider.sv
module mtb_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  mtb_pkg::div_ctrl_type ctrl,
   output mtb_pkg::div_stat_type stat
);

   localparam int unsigned SW = mtb_pkg::SUM_WIDTH;
   localparam int unsigned QW = mtb_pkg::QUO_WIDTH;

   logic [SW-1:0]                   rem_ff, rem_in;
   logic [SW-1:0]                   dvs_ff, dvs_in;
   logic [QW-1:0]                   quo_ff, quo_in;
   logic [mtb_pkg::STEP_WIDTH-1:0]  step_ff, step_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic                            fits;

   // quotient never exceeds eight bits: the sum is at most 255 per pixel
   assign fits = rem_ff >= dvs_ff;

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in  = ctrl.dividend;
         dvs_in  = {ctrl.divisor, {(SW - mtb_pkg::COUNT_WIDTH){1'b0}}};
         quo_in  = '0;
         step_in = mtb_pkg::STEP_WIDTH'(QW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dvs_ff;
         end
         quo_in = {quo_ff[QW-2:0], fits};
         dvs_in = dvs_ff >> 1;
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign stat.busy     = busy_ff;
   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule

// File: hdl/mean_threshold_binarizer_core.sv
// a threshold word is registered on acceptance, and its result enters the rsp register from the execute state
// a new word is accepted only in the idle state, so a word finishes its execute step before the next is taken
// the last accumulate word also runs the 8-step divider to set the mean
// a result waiting in the output register stalls only the next threshold word
// synchronous reset clears the sum, the count, the mean, the sequencer and rsp valid
module mean_threshold_binarizer_core (
   input logic      clock,
   input logic      reset,
   mtb_req_if.sink  req_chan,
   mtb_rsp_if.source rsp_chan
);

   localparam int unsigned CW = mtb_pkg::CHAN_WIDTH;
   localparam int unsigned SW = mtb_pkg::SUM_WIDTH;
   localparam int unsigned NW = mtb_pkg::COUNT_WIDTH;

   typedef enum logic [2:0] {
      IDLE   = 3'b001,
      EXEC   = 3'b010,
      DIVIDE = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [SW-1:0]           sum_ff, sum_in, sum_acc;
   logic [NW-1:0]           count_ff, count_in, count_acc;
   logic [CW-1:0]           mean_ff, mean_in;
   logic                    kind_ff;
   logic                    last_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]           level_ff, level_in;
   logic [CW-1:0]           thresh_ff, thresh_in;
   logic                    eof_ff, eof_in;
   logic                    accept;
   logic                    rsp_free;
   logic [CW-1:0]           gray;
   mtb_pkg::div_ctrl_type   div_ctrl;
   mtb_pkg::div_stat_type   div_stat;

   assign req_chan.ready = (state_ff == IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   mtb_gray u_gray (
      .clock (clock),
      .load  (accept),
      .red   (req_chan.red),
      .green (req_chan.green),
      .blue  (req_chan.blue),
      .gray  (gray)
   );

   mtb_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   // accumulate unless the count has hit its limit
   always_comb begin
      if (count_ff < mtb_pkg::COUNT_LIMIT) begin
         sum_acc   = sum_ff + SW'(gray);
         count_acc = count_ff + 1'b1;
      end else begin
         sum_acc   = sum_ff;
         count_acc = count_ff;
      end
   end

   always_comb begin
      state_in          = state_ff;
      sum_in            = sum_ff;
      count_in          = count_ff;
      mean_in           = mean_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_chan.ready;
      level_in          = level_ff;
      thresh_in         = thresh_ff;
      eof_in            = eof_ff;
      div_ctrl.start    = 1'b0;
      div_ctrl.dividend = sum_acc;
      div_ctrl.divisor  = count_acc;
      case (state_ff)
         IDLE: begin
            if (accept) begin
               state_in = EXEC;
            end
         end
         EXEC: begin
            if (kind_ff == mtb_pkg::KIND_ACCUM) begin
               state_in = IDLE;
               sum_in   = sum_acc;
               count_in = count_acc;
               if (last_ff) begin
                  sum_in   = '0;
                  count_in = '0;
                  if (count_acc == '0) begin
                     mean_in = '0;
                  end else begin
                     div_ctrl.start = 1'b1;
                     state_in       = DIVIDE;
                  end
               end
            end else if (rsp_free) begin
               state_in     = IDLE;
               rsp_valid_in = 1'b1;
               level_in     = (gray >= mean_ff) ? mtb_pkg::LEVEL_WHITE
                                                : mtb_pkg::LEVEL_BLACK;
               thresh_in    = mean_ff;
               eof_in       = last_ff;
            end
         end
         DIVIDE: begin
            if (div_stat.done) begin
               mean_in  = div_stat.quotient;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         mean_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         kind_ff <= req_chan.req_type;
         last_ff <= req_chan.last_pixel;
      end
      level_ff  <= level_in;
      thresh_ff <= thresh_in;
      eof_ff    <= eof_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.level        = level_ff;
   assign rsp_chan.threshold    = thresh_ff;
   assign rsp_chan.end_of_frame = eof_ff;

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mtb_pkg::COUNT_LIMIT)
      else $error("pixel count beyond its limit");

   a_div_only_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == DIVIDE)
      else $error("divider running outside the divide state");

   a_level_binary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (level_ff == mtb_pkg::LEVEL_WHITE || level_ff == mtb_pkg::LEVEL_BLACK))
      else $error("level is neither black nor white");

   a_mean_source: assert property (@(posedge clock) disable iff (reset)
      (!$stable(mean_ff) && !$past(reset)) |->
         ($past(div_stat.done) || $past(state_ff == EXEC && last_ff)))
      else $error("mean changed without an end of accumulate pass");

endmodule

// File: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FEED_TARGET = 1500;
   localparam int unsigned IDLE_LIMIT  = 2000;
   localparam int unsigned TAIL_CYCLES = 24;

   typedef struct packed {
      logic                           kind;
      logic [mtb_pkg::CHAN_WIDTH-1:0] red;
      logic [mtb_pkg::CHAN_WIDTH-1:0] green;
      logic [mtb_pkg::CHAN_WIDTH-1:0] blue;
      logic                           last;
   } pixel_word_type;

   typedef struct packed {
      logic [mtb_pkg::CHAN_WIDTH-1:0] level;
      logic [mtb_pkg::CHAN_WIDTH-1:0] threshold;
      logic                           end_of_frame;
   } binary_word_type;

   typedef enum int {FLOW_FREE, FLOW_COIN, FLOW_SPARSE, FLOW_LONG} flow_mode_type;

   logic clock;
   logic reset;

   mtb_req_if req_chan();
   mtb_rsp_if rsp_chan();

   mean_threshold_binarizer_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pixel_word_type  pixel_feed[$];
   binary_word_type binarized_q[$];

   // running mean of the accumulate pass
   logic [mtb_pkg::SUM_WIDTH-1:0]   gray_total;
   logic [mtb_pkg::COUNT_WIDTH-1:0] gray_pixels;
   logic [mtb_pkg::CHAN_WIDTH-1:0]  frame_mean;

   int unsigned error_count = 0;
   int unsigned words_queued = 0;
   int unsigned words_taken = 0;
   int unsigned idle_cycles;
   int unsigned burst_left;
   int unsigned gap_left;
   int unsigned mode_left;
   int unsigned run_left;
   flow_mode_type flow_mode;

   function automatic pixel_word_type px(logic kind, logic [mtb_pkg::CHAN_WIDTH-1:0] r,
                                         logic [mtb_pkg::CHAN_WIDTH-1:0] g,
                                         logic [mtb_pkg::CHAN_WIDTH-1:0] b,
                                         logic last);
      pixel_word_type w;
      w.kind  = kind;
      w.red   = r;
      w.green = g;
      w.blue  = b;
      w.last  = last;
      return w;
   endfunction

   function automatic logic [mtb_pkg::CHAN_WIDTH-1:0] chan_near(int base, int spread);
      int v;
      if (spread >= 255) return mtb_pkg::CHAN_WIDTH'($urandom_range(0, 255));
      v = base - spread + int'($urandom_range(0, 2 * spread));
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return mtb_pkg::CHAN_WIDTH'(v);
   endfunction

   function automatic pixel_word_type rand_pixel(logic kind, logic last, int base,
                                                 int spread);
      return px(kind, chan_near(base, spread), chan_near(base, spread),
                chan_near(base, spread), last);
   endfunction

   function automatic logic [mtb_pkg::CHAN_WIDTH-1:0] gray_level(pixel_word_type w);
      logic [mtb_pkg::RGB_WIDTH-1:0] total;
      total = mtb_pkg::RGB_WIDTH'(w.red) + mtb_pkg::RGB_WIDTH'(w.green)
            + mtb_pkg::RGB_WIDTH'(w.blue);
      return mtb_pkg::CHAN_WIDTH'(total / 3);
   endfunction

   task automatic track_pixel(input pixel_word_type w);
      logic [mtb_pkg::CHAN_WIDTH-1:0] gray;
      binary_word_type                res;
      gray = gray_level(w);
      if (w.kind == mtb_pkg::KIND_ACCUM) begin
         // count saturates, sum and count hold from then on
         if (gray_pixels < mtb_pkg::COUNT_LIMIT) begin
            gray_total  = gray_total + mtb_pkg::SUM_WIDTH'(gray);
            gray_pixels = gray_pixels + 1'b1;
         end
         if (w.last) begin
            if (gray_pixels == '0) frame_mean = '0;
            else frame_mean = mtb_pkg::CHAN_WIDTH'(gray_total / gray_pixels);
            gray_total  = '0;
            gray_pixels = '0;
         end
      end else begin
         res.level        = (gray >= frame_mean) ? mtb_pkg::LEVEL_WHITE
                                                 : mtb_pkg::LEVEL_BLACK;
         res.threshold    = frame_mean;
         res.end_of_frame = w.last;
         binarized_q.push_back(res);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin : driver
      pixel_word_type w;
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
         if (gap_left > 0 || pixel_feed.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_chan.valid <= 1'b0;
         end else begin
            w = pixel_feed.pop_front();
            req_chan.req_type   <= w.kind;
            req_chan.red        <= w.red;
            req_chan.green      <= w.green;
            req_chan.blue       <= w.blue;
            req_chan.last_pixel <= w.last;
            req_chan.valid      <= 1'b1;
            burst_left--;
         end
      end
   end

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         flow_mode = FLOW_FREE;
         mode_left = 0;
         run_left  = 0;
      end else begin
         if (mode_left == 0) begin
            flow_mode = flow_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 256);
         end else begin
            mode_left--;
         end
         case (flow_mode)
            FLOW_FREE: rsp_chan.ready <= 1'b1;
            FLOW_COIN: rsp_chan.ready <= 1'($urandom_range(0, 1));
            FLOW_SPARSE: rsp_chan.ready <= (mode_left % 4 == 0);
            default: begin
               // long runs of stall and flow
               if (run_left == 0) begin
                  run_left = $urandom_range(1, 20);
                  rsp_chan.ready <= ~rsp_chan.ready;
               end else begin
                  run_left--;
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin : monitor
      pixel_word_type  w;
      binary_word_type want;
      if (reset) begin
         gray_total  = '0;
         gray_pixels = '0;
         frame_mean  = '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            w = px(req_chan.req_type, req_chan.red, req_chan.green, req_chan.blue,
                   req_chan.last_pixel);
            track_pixel(w);
            words_taken++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (binarized_q.size() == 0) begin
               $display("%0t: unexpected word level %0d threshold %0d end_of_frame %0b",
                        $time, rsp_chan.level, rsp_chan.threshold, rsp_chan.end_of_frame);
               error_count++;
            end else begin
               want = binarized_q.pop_front();
               if (rsp_chan.level !== want.level) begin
                  $display("%0t: level expected %0d actual %0d",
                           $time, want.level, rsp_chan.level);
                  error_count++;
               end
               if (rsp_chan.threshold !== want.threshold) begin
                  $display("%0t: threshold expected %0d actual %0d",
                           $time, want.threshold, rsp_chan.threshold);
                  error_count++;
               end
               if (rsp_chan.end_of_frame !== want.end_of_frame) begin
                  $display("%0t: end_of_frame expected %0b actual %0b",
                           $time, want.end_of_frame, rsp_chan.end_of_frame);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      pixel_word_type frame[$];
      pixel_word_type w;
      int unsigned n;
      int unsigned pick;
      int          base;
      int          spread;
      bit          reuse;

      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.req_type   = mtb_pkg::KIND_ACCUM;
      req_chan.red        = '0;
      req_chan.green      = '0;
      req_chan.blue       = '0;
      req_chan.last_pixel = 1'b0;
      rsp_chan.ready      = 1'b0;

      // threshold before any accumulate: mean is still zero
      pixel_feed.push_back(px(mtb_pkg::KIND_THRESH, 8'd0, 8'd0, 8'd0, 1'b0));
      pixel_feed.push_back(px(mtb_pkg::KIND_THRESH, 8'd255, 8'd255, 8'd255, 1'b1));
      // threshold word in the middle of an open accumulate pass
      pixel_feed.push_back(px(mtb_pkg::KIND_ACCUM, 8'd255, 8'd255, 8'd255, 1'b0));
      pixel_feed.push_back(px(mtb_pkg::KIND_THRESH, 8'd0, 8'd0, 8'd0, 1'b0));
      pixel_feed.push_back(px(mtb_pkg::KIND_ACCUM, 8'd255, 8'd0, 8'd0, 1'b0));
      pixel_feed.push_back(px(mtb_pkg::KIND_ACCUM, 8'd0, 8'd255, 8'd1, 1'b0));
      pixel_feed.push_back(px(mtb_pkg::KIND_ACCUM, 8'd0, 8'd0, 8'd255, 1'b1));
      // gray equal to the mean, then one below
      pixel_feed.push_back(px(mtb_pkg::KIND_THRESH, 8'd127, 8'd127, 8'd128, 1'b0));
      pixel_feed.push_back(px(mtb_pkg::KIND_THRESH, 8'd126, 8'd127, 8'd127, 1'b0));
      pixel_feed.push_back(px(mtb_pkg::KIND_THRESH, 8'd255, 8'd255, 8'd255, 1'b1));
      // single black pixel frame
      pixel_feed.push_back(px(mtb_pkg::KIND_ACCUM, 8'd0, 8'd0, 8'd0, 1'b1));
      pixel_feed.push_back(px(mtb_pkg::KIND_THRESH, 8'd1, 8'd0, 8'd0, 1'b1));
      pixel_feed.push_back(px(mtb_pkg::KIND_ACCUM, 8'd100, 8'd100, 8'd100, 1'b1));
      pixel_feed.push_back(px(mtb_pkg::KIND_THRESH, 8'd100, 8'd100, 8'd101, 1'b0));
      pixel_feed.push_back(px(mtb_pkg::KIND_THRESH, 8'd99, 8'd99, 8'd99, 1'b0));
      pixel_feed.push_back(px(mtb_pkg::KIND_THRESH, 8'd0, 8'd255, 8'd0, 1'b1));
      // full white mean
      pixel_feed.push_back(px(mtb_pkg::KIND_ACCUM, 8'd255, 8'd255, 8'd255, 1'b1));
      pixel_feed.push_back(px(mtb_pkg::KIND_THRESH, 8'd255, 8'd255, 8'd254, 1'b0));
      pixel_feed.push_back(px(mtb_pkg::KIND_THRESH, 8'd255, 8'd255, 8'd255, 1'b1));

      while (pixel_feed.size() < FEED_TARGET) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            pixel_feed.push_back(rand_pixel(1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)), 128, 255));
         end else begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 12);
            base = $urandom_range(0, 255);
            case ($urandom_range(0, 2))
               0: spread = 255;
               1: spread = 24;
               default: spread = 3;
            endcase
            frame.delete();
            for (int i = 0; i < n; i++)
               frame.push_back(rand_pixel(mtb_pkg::KIND_ACCUM, i == n - 1, base, spread));
            // pass left open, so the next frame carries its sum on
            if (pick == 1) frame[n-1].last = 1'b0;
            foreach (frame[i]) begin
               pixel_feed.push_back(frame[i]);
               if (pick == 2 && i == n / 2)
                  pixel_feed.push_back(rand_pixel(mtb_pkg::KIND_THRESH, 1'b0, base, spread));
            end
            reuse = ($urandom_range(0, 3) != 0);
            foreach (frame[i]) begin
               w = reuse ? frame[i] : rand_pixel(mtb_pkg::KIND_THRESH, 1'b0, base, spread);
               w.kind = mtb_pkg::KIND_THRESH;
               w.last = (i == n - 1) && (pick != 3);
               pixel_feed.push_back(w);
            end
         end
      end
      words_queued = pixel_feed.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (words_taken < words_queued) @(posedge clock);
      while (binarized_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
